// ===== hw/rtl/text_console_writer_defines.svh =====
// Assertion macros shared by the console writer RTL.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define CTW_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define CTW_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/ctw_pkg.sv =====
// Types, constants and address helpers for the text console writer.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package ctw_pkg;

  localparam int SCREEN_COLS = 80;
  localparam int SCREEN_ROWS = 25;
  localparam int CELL_COUNT  = SCREEN_COLS * SCREEN_ROWS;

  localparam int COL_W   = $clog2(SCREEN_COLS);
  localparam int ROW_W   = $clog2(SCREEN_ROWS);
  localparam int CELL_AW = $clog2(CELL_COUNT);

  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_BLANK   = 8'h20;

  localparam logic [7:0] ATTR_DEFAULT_RST = 8'h0F;
  localparam logic [7:0] ATTR_DEBUG_RST   = 8'h0A;
  localparam logic [7:0] ATTR_ERROR_RST   = 8'h4F;
  localparam logic [7:0] ATTR_CLEAR_RST   = 8'h07;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_READ  = 1'b1;

  localparam logic [1:0] KIND_DEFAULT = 2'd0;
  localparam logic [1:0] KIND_DEBUG   = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;
  localparam logic [1:0] KIND_KEEP    = 2'd3;

  typedef enum logic [1:0] {
    REG_DEFAULT_ATTR = 2'd0,
    REG_DEBUG_ATTR   = 2'd1,
    REG_ERROR_ATTR   = 2'd2,
    REG_CLEAR_ATTR   = 2'd3
  } cfg_reg_e;

  typedef enum logic [3:0] {
    S_CLEAR  = 4'b0001,
    S_IDLE   = 4'b0010,
    S_READ   = 4'b0100,
    S_SCROLL = 4'b1000
  } ctw_state_e;

  typedef struct packed {
    logic       func;
    logic [7:0] char_code;
    logic [1:0] log_kind;
    logic [4:0] read_row;
    logic [6:0] read_col;
  } in_item_t;

  typedef struct packed {
    logic [7:0] cell_char;
    logic [7:0] cell_attr;
    logic [6:0] cursor_col;
    logic [4:0] cursor_row;
    logic       scrolled;
  } out_item_t;

  typedef struct packed {
    logic [7:0] attr;
    logic [7:0] ch;
  } cell_t;

  typedef struct packed {
    logic [7:0] default_attr;
    logic [7:0] debug_attr;
    logic [7:0] error_attr;
    logic [7:0] clear_attr;
  } attr_cfg_t;

  typedef struct packed {
    logic clearing;
    logic scrolling;
  } ctw_status_t;

  // Physical row after the last one wraps to the first.
  function automatic logic [ROW_W-1:0] row_inc(input logic [ROW_W-1:0] r);
    logic [ROW_W-1:0] n;
    n = (r == ROW_W'(SCREEN_ROWS - 1)) ? '0 : r + ROW_W'(1);
    return n;
  endfunction

  function automatic logic [CELL_AW-1:0] cell_addr(input logic [ROW_W-1:0] prow,
                                                   input logic [COL_W-1:0] col);
    logic [CELL_AW-1:0] a;
    a = CELL_AW'(prow) * CELL_AW'(SCREEN_COLS) + CELL_AW'(col);
    return a;
  endfunction

endpackage

// ===== hw/rtl/ctw_cell_ram.sv =====
// Cell store: one write port, one read port with registered read data.
// Depends on ctw_pkg for depth and cell type.
`timescale 1ns / 1ps

module ctw_cell_ram import ctw_pkg::*; (
  input  logic               clk_i,
  input  logic               wr_en_i,
  input  logic [CELL_AW-1:0] wr_addr_i,
  input  cell_t              wr_data_i,
  input  logic               rd_en_i,
  input  logic [CELL_AW-1:0] rd_addr_i,
  output cell_t              rd_data_o
);

  cell_t mem_q [CELL_COUNT];
  cell_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== hw/rtl/ctw_ctrl.sv =====
// Sequencer for the console: cursor, current attribute, row ring offset,
// reset clearing sweep and row fill on scroll. Depends on ctw_pkg.
`timescale 1ns / 1ps

module ctw_ctrl import ctw_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_item_t           in_item_i,
  input  logic               out_free_i,
  input  attr_cfg_t          cfg_i,
  output logic               res_valid_o,
  output out_item_t          res_o,
  output ctw_status_t        status_o,
  output logic               wr_en_o,
  output logic [CELL_AW-1:0] wr_addr_o,
  output cell_t              wr_data_o,
  output logic               rd_en_o,
  output logic [CELL_AW-1:0] rd_addr_o,
  input  cell_t              rd_data_i
);

  ctw_state_e         state_q, state_d;
  logic [COL_W-1:0]   col_q, col_d;
  logic [ROW_W-1:0]   row_q, row_d;
  logic [ROW_W-1:0]   prow_q, prow_d;   // physical row of the cursor
  logic [ROW_W-1:0]   top_q, top_d;     // physical row shown as row 0
  logic [7:0]         attr_q, attr_d;
  logic [CELL_AW-1:0] clr_cnt_q, clr_cnt_d;
  logic [COL_W-1:0]   fill_col_q, fill_col_d;
  logic               oob_q, oob_d;
  out_item_t          res_q, res_d;

  logic               accept;
  logic               is_nl;
  logic               is_tab;
  logic [7:0]         attr_new;
  logic [COL_W:0]     col_adv;
  logic               wrap;
  logic               last_row;
  logic               do_scroll;
  logic [COL_W-1:0]   w_col;
  logic [ROW_W-1:0]   w_row;
  logic [ROW_W-1:0]   w_prow;
  out_item_t          wres;
  logic               rd_inrange;
  logic [ROW_W:0]     rprow_sum;
  logic [ROW_W-1:0]   rprow;
  logic               fill_last;
  logic               clr_last;

  assign in_ready_o = (state_q == S_IDLE) && out_free_i;
  assign accept     = in_valid_i && in_ready_o;

  // Write item: attribute, cursor advance, wrap and scroll decision
  always_comb begin
    case (in_item_i.log_kind)
      KIND_DEFAULT: attr_new = cfg_i.default_attr;
      KIND_DEBUG:   attr_new = cfg_i.debug_attr;
      KIND_ERROR:   attr_new = cfg_i.error_attr;
      default:      attr_new = attr_q;
    endcase
  end

  assign is_nl     = (in_item_i.char_code == CH_NEWLINE);
  assign is_tab    = (in_item_i.char_code == CH_TAB);
  assign col_adv   = is_tab ? ({1'b0, col_q} + (COL_W+1)'(4))
                            : ({1'b0, col_q} + (COL_W+1)'(1));
  assign wrap      = is_nl || (col_adv >= (COL_W+1)'(SCREEN_COLS));
  assign last_row  = (row_q == ROW_W'(SCREEN_ROWS - 1));
  assign do_scroll = wrap && last_row;
  assign w_col     = wrap ? '0 : col_adv[COL_W-1:0];
  assign w_row     = (wrap && !last_row) ? row_q + ROW_W'(1) : row_q;
  // On scroll the old top row becomes the new last row
  assign w_prow    = wrap ? (last_row ? top_q : row_inc(prow_q)) : prow_q;

  always_comb begin
    wres            = '0;
    wres.cursor_col = 7'(w_col);
    wres.cursor_row = 5'(w_row);
    wres.scrolled   = do_scroll;
  end

  // Read item: map the screen row through the ring offset
  assign rd_inrange = ({1'b0, in_item_i.read_row} < 6'(SCREEN_ROWS)) &&
                      ({1'b0, in_item_i.read_col} < 8'(SCREEN_COLS));
  assign rprow_sum  = {1'b0, in_item_i.read_row[ROW_W-1:0]} + {1'b0, top_q};
  assign rprow      = (rprow_sum >= (ROW_W+1)'(SCREEN_ROWS))
                    ? ROW_W'(rprow_sum - (ROW_W+1)'(SCREEN_ROWS))
                    : rprow_sum[ROW_W-1:0];

  assign fill_last = (fill_col_q == COL_W'(SCREEN_COLS - 1));
  assign clr_last  = (clr_cnt_q == CELL_AW'(CELL_COUNT - 1));

  assign rd_en_o   = accept && (in_item_i.func == FUNC_READ);
  assign rd_addr_o = cell_addr(rprow, in_item_i.read_col[COL_W-1:0]);

  always_comb begin
    state_d     = state_q;
    col_d       = col_q;
    row_d       = row_q;
    prow_d      = prow_q;
    top_d       = top_q;
    attr_d      = attr_q;
    clr_cnt_d   = clr_cnt_q;
    fill_col_d  = fill_col_q;
    oob_d       = oob_q;
    res_d       = res_q;
    res_valid_o = 1'b0;
    res_o       = wres;
    wr_en_o     = 1'b0;
    wr_addr_o   = cell_addr(prow_q, col_q);
    wr_data_o   = '{attr: attr_new, ch: in_item_i.char_code};

    unique case (state_q)
      S_CLEAR: begin
        wr_en_o   = 1'b1;
        wr_addr_o = clr_cnt_q;
        wr_data_o = '{attr: ATTR_CLEAR_RST, ch: CH_BLANK};
        clr_cnt_d = clr_cnt_q + CELL_AW'(1);
        if (clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept && (in_item_i.func == FUNC_READ)) begin
          oob_d   = !rd_inrange;
          state_d = S_READ;
        end else if (accept) begin
          attr_d  = attr_new;
          col_d   = w_col;
          row_d   = w_row;
          prow_d  = w_prow;
          wr_en_o = !is_nl && !is_tab;
          if (do_scroll) begin
            top_d      = row_inc(top_q);
            fill_col_d = '0;
            res_d      = wres;
            state_d    = S_SCROLL;
          end else begin
            res_valid_o = 1'b1;
          end
        end
      end
      S_READ: begin
        res_valid_o      = 1'b1;
        res_o            = '0;
        res_o.cell_char  = oob_q ? CH_BLANK : rd_data_i.ch;
        res_o.cell_attr  = oob_q ? cfg_i.clear_attr : rd_data_i.attr;
        res_o.cursor_col = 7'(col_q);
        res_o.cursor_row = 5'(row_q);
        state_d          = S_IDLE;
      end
      S_SCROLL: begin
        // Blank the new last row, one cell a cycle
        wr_en_o    = 1'b1;
        wr_addr_o  = cell_addr(prow_q, fill_col_q);
        wr_data_o  = '{attr: cfg_i.clear_attr, ch: CH_BLANK};
        fill_col_d = fill_col_q + COL_W'(1);
        res_o      = res_q;
        if (fill_last) begin
          res_valid_o = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign status_o = '{clearing: (state_q == S_CLEAR), scrolling: (state_q == S_SCROLL)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      col_q      <= '0;
      row_q      <= '0;
      prow_q     <= '0;
      top_q      <= '0;
      attr_q     <= ATTR_DEFAULT_RST;
      clr_cnt_q  <= '0;
      fill_col_q <= '0;
      oob_q      <= 1'b0;
    end else begin
      state_q    <= state_d;
      col_q      <= col_d;
      row_q      <= row_d;
      prow_q     <= prow_d;
      top_q      <= top_d;
      attr_q     <= attr_d;
      clr_cnt_q  <= clr_cnt_d;
      fill_col_q <= fill_col_d;
      oob_q      <= oob_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

endmodule

// ===== hw/rtl/text_console_writer.sv =====
// Text console writer. Plain write item: one item per cycle while the output register
// is free. Read item: passes through S_READ (registered cell store read). A write that
// scrolls passes through S_SCROLL, one cell write per cycle to blank a row.
// Result sits in an output register; the next item enters when it frees.
// Reset: registers return to reset values, then a clearing pass over all CELL_COUNT
// cells blanks the store; no item is accepted meanwhile.
`timescale 1ns / 1ps
`include "text_console_writer_defines.svh"

module text_console_writer import ctw_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  cfg_reg_e  cfg_index_i,
  input  logic [7:0] cfg_data_i
);

  attr_cfg_t          cfg_q;
  logic               out_valid_q, out_valid_d;
  out_item_t          out_item_q;
  logic               out_free;
  logic               res_valid;
  out_item_t          res;
  ctw_status_t        status;
  logic               wr_en;
  logic [CELL_AW-1:0] wr_addr;
  cell_t              wr_data;
  logic               rd_en;
  logic [CELL_AW-1:0] rd_addr;
  cell_t              rd_data;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{default_attr: ATTR_DEFAULT_RST, debug_attr: ATTR_DEBUG_RST,
                 error_attr: ATTR_ERROR_RST, clear_attr: ATTR_CLEAR_RST};
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_DEFAULT_ATTR: cfg_q.default_attr <= cfg_data_i;
        REG_DEBUG_ATTR:   cfg_q.debug_attr   <= cfg_data_i;
        REG_ERROR_ATTR:   cfg_q.error_attr   <= cfg_data_i;
        REG_CLEAR_ATTR:   cfg_q.clear_attr   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  ctw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_free_i  (out_free),
    .cfg_i       (cfg_q),
    .res_valid_o (res_valid),
    .res_o       (res),
    .status_o    (status),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data)
  );

  ctw_cell_ram u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Output register: load a finished result, drop it once taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  `CTW_ASSERT_IMP(a_no_result_overwrite, res_valid, !out_valid_q || out_ready_i, "result would overwrite an untaken item")
  `CTW_ASSERT_IMP(a_busy_blocks_input, status.clearing || status.scrolling, !in_ready_o, "input accepted during clear or scroll")
  `CTW_ASSERT_IMP(a_scroll_cursor, res_valid && res.scrolled, res.cursor_row == 5'(SCREEN_ROWS - 1) && res.cursor_col == 7'd0, "scroll left cursor off the last row start")
  `CTW_ASSERT_NXT(a_read_result, in_valid_i && in_ready_o && in_item_i.func == FUNC_READ, res_valid, "read item gave no result after one cycle")

endmodule

// ===== sim/text_console_writer_checker.sv =====
// Checker for the text console writer: mirrors the cell grid, cursor and attributes,
// predicts one result per accepted item and compares results in order.
// Depends on ctw_pkg for the item, cell and register types.
`timescale 1ns / 1ps

module text_console_writer_checker import ctw_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  in_item_t   in_item_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  out_item_t  out_item_i,
  input  logic       cfg_valid_i,
  input  logic       cfg_ready_i,
  input  cfg_reg_e   cfg_index_i,
  input  logic [7:0] cfg_data_i,
  input  logic       done_i,
  output int         errors_o
);

  cell_t      screen [SCREEN_ROWS][SCREEN_COLS];
  int         cur_col;
  int         cur_row;
  logic [7:0] cur_attr;
  attr_cfg_t  attrs;
  out_item_t  pending_results [$];
  int         n_bad;
  bit         done_seen;

  assign errors_o = n_bad;

  function automatic cell_t blank_cell();
    cell_t c;
    c.attr = attrs.clear_attr;
    c.ch   = CH_BLANK;
    return c;
  endfunction

  // Go to column 0 of the next row; scroll the grid up when leaving the last row.
  function automatic bit line_feed();
    cur_col = 0;
    cur_row++;
    if (cur_row < SCREEN_ROWS) return 1'b0;
    for (int r = 0; r < SCREEN_ROWS - 1; r++) begin
      for (int c = 0; c < SCREEN_COLS; c++) screen[r][c] = screen[r+1][c];
    end
    for (int c = 0; c < SCREEN_COLS; c++) screen[SCREEN_ROWS-1][c] = blank_cell();
    cur_row = SCREEN_ROWS - 1;
    return 1'b1;
  endfunction

  function automatic out_item_t apply_console_item(in_item_t it);
    out_item_t res;
    cell_t     c;
    bit        scr;
    res = '0;
    scr = 1'b0;
    if (it.func == FUNC_READ) begin
      c = blank_cell();
      if (it.read_row < SCREEN_ROWS && it.read_col < SCREEN_COLS) begin
        c = screen[it.read_row][it.read_col];
      end
      res.cell_char = c.ch;
      res.cell_attr = c.attr;
    end else begin
      case (it.log_kind)
        KIND_DEFAULT: cur_attr = attrs.default_attr;
        KIND_DEBUG:   cur_attr = attrs.debug_attr;
        KIND_ERROR:   cur_attr = attrs.error_attr;
        default: ;
      endcase
      if (it.char_code == CH_NEWLINE) begin
        scr = line_feed();
      end else if (it.char_code == CH_TAB) begin
        cur_col += 4;
      end else begin
        c.ch   = it.char_code;
        c.attr = cur_attr;
        if (cur_col < SCREEN_COLS) screen[cur_row][cur_col] = c;
        cur_col++;
      end
      if (cur_col >= SCREEN_COLS) scr = line_feed() | scr;
    end
    res.cursor_col = 7'(cur_col);
    res.cursor_row = 5'(cur_row);
    res.scrolled   = scr;
    return res;
  endfunction

  function automatic string show(out_item_t r);
    return $sformatf("char=%h attr=%h col=%0d row=%0d scrolled=%b",
                     r.cell_char, r.cell_attr, r.cursor_col, r.cursor_row, r.scrolled);
  endfunction

  function automatic void note_fail(string msg);
    n_bad++;
    if (n_bad <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    out_item_t exp;
    if (!rst_ni) begin
      attrs.default_attr = ATTR_DEFAULT_RST;
      attrs.debug_attr   = ATTR_DEBUG_RST;
      attrs.error_attr   = ATTR_ERROR_RST;
      attrs.clear_attr   = ATTR_CLEAR_RST;
      for (int r = 0; r < SCREEN_ROWS; r++) begin
        for (int c = 0; c < SCREEN_COLS; c++) screen[r][c] = blank_cell();
      end
      cur_col   = 0;
      cur_row   = 0;
      cur_attr  = ATTR_DEFAULT_RST;
      n_bad     = 0;
      done_seen = 1'b0;
      pending_results.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_DEFAULT_ATTR: attrs.default_attr = cfg_data_i;
          REG_DEBUG_ATTR:   attrs.debug_attr   = cfg_data_i;
          REG_ERROR_ATTR:   attrs.error_attr   = cfg_data_i;
          REG_CLEAR_ATTR:   attrs.clear_attr   = cfg_data_i;
          default: ;
        endcase
      end
      // Compare before predicting: a result never belongs to an item taken this cycle.
      if (out_valid_i && out_ready_i) begin
        if (pending_results.size() == 0) begin
          note_fail($sformatf("unexpected result %s", show(out_item_i)));
        end else begin
          exp = pending_results.pop_front();
          if (exp.cell_char !== out_item_i.cell_char ||
              exp.cell_attr !== out_item_i.cell_attr ||
              exp.cursor_col !== out_item_i.cursor_col ||
              exp.cursor_row !== out_item_i.cursor_row ||
              exp.scrolled !== out_item_i.scrolled) begin
            note_fail($sformatf("expected %s, got %s", show(exp), show(out_item_i)));
          end
        end
      end
      if (in_valid_i && in_ready_i) pending_results.push_back(apply_console_item(in_item_i));
      if (done_i && !done_seen) begin
        done_seen = 1'b1;
        if (pending_results.size() != 0) begin
          note_fail($sformatf("%0d results never arrived", pending_results.size()));
        end
      end
    end
  end

endmodule

// ===== sim/text_console_writer_tb.sv =====
// Testbench top for the text console writer: clock, reset, item and register stimulus.
// Depends on ctw_pkg, text_console_writer and text_console_writer_checker.
`timescale 1ns / 1ps

module text_console_writer_tb import ctw_pkg::*; ();

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int PHASES         = 6;
  localparam int PHASE_ITEMS    = 255;
  localparam int HOLD_AT        = 400;
  localparam int HOLD_CYCLES    = 300;
  localparam int ITEM_W         = $bits(in_item_t);

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  in_item_t   in_item;
  logic       out_valid;
  logic       out_ready;
  out_item_t  out_item;
  logic       cfg_valid;
  logic       cfg_ready;
  cfg_reg_e   cfg_index;
  logic [7:0] cfg_data;
  logic       done;
  int         errors;

  int n_sent = 0;
  int n_out = 0;
  int idle_cycles = 0;
  int send_calm = 0;
  bit quiet = 1'b0;

  always #1 clk = ~clk;

  text_console_writer dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  text_console_writer_checker console_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_item_i   (in_item),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_item_i  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .done_i      (done),
    .errors_o    (errors)
  );

  always @(posedge clk) begin
    if (out_valid && out_ready) n_out++;
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result side: short random stalls, calm stretches, and one long hold-off.
  initial begin : result_side
    int  hold_left;
    int  stall_left;
    int  calm_left;
    bit  held;
    logic rdy;
    hold_left  = 0;
    stall_left = 0;
    calm_left  = 0;
    held       = 1'b0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (!held && n_out >= HOLD_AT) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        rdy       = 1'b0;
      end else if (quiet) begin
        rdy = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        rdy = 1'b0;
      end else if (calm_left > 0) begin
        calm_left--;
        rdy = 1'b1;
      end else if ($urandom_range(0, 39) == 0) begin
        calm_left = $urandom_range(20, 60);
        rdy       = 1'b1;
      end else if ($urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 6) - 1;
        rdy        = 1'b0;
      end else begin
        rdy = 1'b1;
      end
      out_ready <= rdy;
    end
  end

  function automatic in_item_t mk_write(logic [7:0] ch, logic [1:0] kind);
    in_item_t it;
    it           = '0;
    it.func      = FUNC_WRITE;
    it.char_code = ch;
    it.log_kind  = kind;
    return it;
  endfunction

  function automatic in_item_t mk_read(logic [4:0] row, logic [6:0] col, logic [1:0] kind);
    in_item_t it;
    it          = '0;
    it.func     = FUNC_READ;
    it.log_kind = kind;
    it.read_row = row;
    it.read_col = col;
    return it;
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    int       pick;
    it   = ITEM_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      it.func = FUNC_READ;
      if ($urandom_range(0, 5) != 0) begin
        it.read_row = 5'($urandom_range(0, SCREEN_ROWS - 1));
        it.read_col = 7'($urandom_range(0, SCREEN_COLS - 1));
      end else if ($urandom_range(0, 1) == 0) begin
        it.read_row = 5'($urandom_range(SCREEN_ROWS, 31));
        it.read_col = 7'($urandom_range(0, 127));
      end else begin
        it.read_row = 5'($urandom_range(0, 31));
        it.read_col = 7'($urandom_range(SCREEN_COLS, 127));
      end
    end else begin
      it.func = FUNC_WRITE;
      pick    = $urandom_range(0, 99);
      if (pick < 8) it.char_code = CH_NEWLINE;
      else if (pick < 14) it.char_code = CH_TAB;
    end
    return it;
  endfunction

  // Called at a falling edge; returns at the falling edge after the item is taken,
  // with valid still high so the next item can follow without a bubble.
  task automatic push_item(input in_item_t it);
    int gap;
    gap = 0;
    if (!quiet && send_calm == 0 && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 6);
    if (send_calm > 0) send_calm--;
    else if ($urandom_range(0, 49) == 0) send_calm = $urandom_range(20, 60);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_sent++;
    @(negedge clk);
  endtask

  task automatic write_attr(input cfg_reg_e idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic load_attrs(input logic [7:0] dflt, input logic [7:0] dbg,
                            input logic [7:0] err, input logic [7:0] clr);
    write_attr(REG_DEFAULT_ATTR, dflt);
    write_attr(REG_DEBUG_ATTR, dbg);
    write_attr(REG_ERROR_ATTR, err);
    write_attr(REG_CLEAR_ATTR, clr);
    cfg_valid <= 1'b0;
  endtask

  // Lower valid, then wait for every outstanding result.
  task automatic drain();
    in_valid <= 1'b0;
    while (n_out != n_sent) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin : stimulus
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_item   = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_DEFAULT_ATTR;
    cfg_data  = '0;
    done      = 1'b0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed items under the reset attributes.
    push_item(mk_read(5'd0, 7'd0, KIND_DEFAULT));
    push_item(mk_write(8'h41, KIND_DEFAULT));
    push_item(mk_write(8'h00, KIND_DEBUG));
    push_item(mk_write(8'hFF, KIND_ERROR));
    push_item(mk_write(8'h6B, KIND_KEEP));
    push_item(mk_write(CH_TAB, KIND_KEEP));
    push_item(mk_write(8'h7E, KIND_KEEP));
    push_item(mk_read(5'd0, 7'd1, KIND_ERROR));
    // A read with a kind must not touch the current attribute.
    push_item(mk_write(8'h5A, KIND_KEEP));
    push_item(mk_write(CH_NEWLINE, KIND_DEBUG));
    push_item(mk_write(8'h80, KIND_KEEP));
    push_item(mk_read(5'd0, 7'd0, KIND_KEEP));
    push_item(mk_read(5'd0, 7'd2, KIND_DEBUG));
    push_item(mk_read(5'd0, 7'd3, KIND_DEFAULT));
    push_item(mk_read(5'd0, 7'd8, KIND_DEFAULT));
    push_item(mk_read(5'd1, 7'd0, KIND_DEFAULT));
    push_item(mk_read(5'(SCREEN_ROWS - 1), 7'(SCREEN_COLS - 1), KIND_DEFAULT));
    push_item(mk_read(5'(SCREEN_ROWS), 7'd0, KIND_DEFAULT));
    push_item(mk_read(5'd0, 7'(SCREEN_COLS), KIND_DEFAULT));
    push_item(mk_read(5'd31, 7'd127, KIND_KEEP));
    push_item(mk_write(CH_TAB, KIND_ERROR));
    push_item(mk_write(8'h20, KIND_KEEP));
    drain();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: load_attrs(8'h00, 8'hFF, 8'h00, 8'hFF);
        1: load_attrs(8'hFF, 8'h00, 8'hFF, 8'h00);
        default: load_attrs(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      endcase
      if (p == PHASES - 1) quiet = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) push_item(random_item());
      drain();
    end

    repeat (100) @(negedge clk);
    done = 1'b1;
    repeat (2) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/ctw_pkg.sv
hw/rtl/ctw_cell_ram.sv
hw/rtl/ctw_ctrl.sv
hw/rtl/text_console_writer.sv
sim/text_console_writer_checker.sv
sim/text_console_writer_tb.sv
